[rtl/ssmg_pkg.sv]
// Shared constants, types and tables for the spherical sector mesh generator.
package ssmg_pkg;
  localparam int ANGLE_FRACTION_BITS = 6;
  localparam int CORDIC_ROUNDS = 18;
  localparam int INDEX_BITS = 20;

  localparam int AZ_W = 16;
  localparam int EL_W = 14;
  localparam int CNT_W = 10;
  localparam int DIV_W = AZ_W + 1 - ANGLE_FRACTION_BITS;
  localparam int DIVISOR_W = 9;
  localparam int MAG_W = 32;
  localparam int CORD_W = 34;
  localparam int ROUND_W = 5;
  localparam int COORD_W = 17;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [33:0] DEG_Q38 = 34'd4797524518;
  localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AZ_START,
    REG_AZ_END,
    REG_EL_START,
    REG_EL_END,
    REG_AZ_STEP,
    REG_EL_STEP,
    REG_RADIUS
  } cfg_reg_t;

  typedef struct packed {
    logic [MAG_W-1:0] smag;
    logic             sneg;
    logic [MAG_W-1:0] cmag;
    logic             cneg;
  } trig_t;

  function automatic logic [31:0] atan_q30(input logic [ROUND_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage

[rtl/ssmg_div.sv]
// Restoring divider, one quotient bit per cycle, for grid point counts.
module ssmg_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ssmg_pkg::DIV_W-1:0]     dividend,
  input  logic [ssmg_pkg::DIVISOR_W-1:0] divisor,
  output logic                           done,
  output logic [ssmg_pkg::DIV_W-1:0]     quotient
);
  import ssmg_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIVISOR_W:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0] trial;
  logic              fits;

  assign trial = {rem[DIVISOR_W-1:0], quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CW'(DIV_W - 1);
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial - {1'b0, dvs} : trial;
      quotient <= {quotient[DIV_W-2:0], fits};
      cnt      <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

[rtl/ssmg_cordic.sv]
// Iterative CORDIC sine and cosine with quadrant folding, one round per cycle.
module ssmg_cordic (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [ssmg_pkg::AZ_W-1:0] angle,
  output logic                             done,
  output ssmg_pkg::trig_t                  result
);
  import ssmg_pkg::*;

  localparam int ANG_W = AZ_W + 1;
  localparam int QUARTER = 90 << ANGLE_FRACTION_BITS;
  localparam int RAD_W = $clog2(QUARTER + 1);
  localparam int ZP_W = RAD_W + 34;
  localparam logic signed [ANG_W-1:0] FULL_A = ANG_W'(360 << ANGLE_FRACTION_BITS);
  localparam logic signed [ANG_W-1:0] HALF_A = ANG_W'(180 << ANGLE_FRACTION_BITS);
  localparam logic signed [ANG_W-1:0] QUART_A = ANG_W'(QUARTER);

  typedef enum logic [1:0] {C_IDLE, C_SCALE, C_ROT} cstate_t;
  cstate_t state;

  logic signed [ANG_W-1:0] a0, a1, a2;
  logic                    flip_c, neg_c;
  logic [RAD_W-1:0]        r_c, r_q;
  logic                    flip_q, neg_q;
  logic [ZP_W-1:0]         zprod;
  logic signed [CORD_W-1:0] x, y, z, xs, ys, at;
  logic [ROUND_W-1:0]      i;

  always_comb begin
    a0 = {angle[AZ_W-1], angle};
    a1 = a0;
    if (a0 >= HALF_A) begin
      a1 = a0 - FULL_A;
    end else if (a0 < -HALF_A) begin
      a1 = a0 + FULL_A;
    end
    flip_c = 1'b0;
    a2 = a1;
    if (a1 > QUART_A) begin
      a2 = a1 - HALF_A;
      flip_c = 1'b1;
    end else if (a1 < -QUART_A) begin
      a2 = a1 + HALF_A;
      flip_c = 1'b1;
    end
    neg_c = a2[ANG_W-1];
    r_c = RAD_W'(neg_c ? -a2 : a2);
  end

  assign zprod = ZP_W'(r_q) * ZP_W'(DEG_Q38);
  assign xs = x >>> i;
  assign ys = y >>> i;
  assign at = CORD_W'(atan_q30(i));

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= C_IDLE;
      i     <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            r_q    <= r_c;
            flip_q <= flip_c;
            neg_q  <= neg_c;
            state  <= C_SCALE;
          end
        end
        C_SCALE: begin
          z <= CORD_W'((zprod + ZP_W'(1 << (7 + ANGLE_FRACTION_BITS)))
                       >> (8 + ANGLE_FRACTION_BITS));
          x <= CORDIC_X0;
          y <= '0;
          i <= '0;
          state <= C_ROT;
        end
        C_ROT: begin
          if (!z[CORD_W-1]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          i <= i + 1'b1;
          if (i == ROUND_W'(CORDIC_ROUNDS - 1)) begin
            state <= C_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_comb begin
    result.cneg = flip_q ^ x[CORD_W-1];
    result.cmag = MAG_W'(x[CORD_W-1] ? -x : x);
    result.sneg = flip_q ^ neg_q ^ y[CORD_W-1];
    result.smag = MAG_W'(y[CORD_W-1] ? -y : y);
  end
endmodule

[rtl/spherical_sector_mesh_generator.sv]
// Top level: grid walk sequencer, shared multiplier and output register.
//
// channel  | handshake          | payload
// s_       | s_tvalid/s_tready  | s_tdata[0] restart
// m_       | m_tvalid/m_tready  | m_tdata vertex, index, corners; m_tuser cell_valid; m_tlast
// cfg_     | cfg_we             | cfg_index, cfg_data
//
// Between acceptance of an advance and the next s_tready, the sequencer runs two
// CORDIC passes on one shared rotator, then four products through one 33x32
// multiplier. A restart adds two 11-step point-count divisions.
// s_tready is high only when the sequencer is idle; a result waiting in m_
// register stalls only the next emit. Synchronous reset clears all walk state
// and loads register defaults.
module spherical_sector_mesh_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // restart
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pos_x, pos_y, pos_z, vertex_number, corner_a, corner_b, corner_c, corner_d, pad
  output logic [151:0]                     m_tdata,
  output logic                             m_tuser,   // cell_valid
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [ssmg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssmg_pkg::CFG_W-1:0]       cfg_data
);
  import ssmg_pkg::*;

  localparam int T_W = 33;
  localparam int P_W = 65;
  localparam int CM_W = 19;
  localparam int AFB = ANGLE_FRACTION_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_EL, S_DIV_AZ, S_CHECK, S_TRIG_AZ, S_TRIG_EL, S_MUL_CE,
    S_ROUND_T, S_MUL_SA, S_MUL_CA, S_MUL_SE, S_ZMAG, S_EMIT
  } state_t;
  state_t state;

  logic signed [AZ_W-1:0] az_start, az_end, az_now;
  logic signed [EL_W-1:0] el_start, el_end, el_now;
  logic [8:0]  az_step;
  logic [7:0]  el_step;
  logic [15:0] radius;

  logic [CNT_W-1:0] col, row, rows, cols;
  logic [INDEX_BITS-1:0] vcount;

  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_dividend, div_q;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  cor_start, cor_done;
  logic signed [AZ_W-1:0] cor_angle;
  trig_t                 cor_res, trig_az, trig_el;

  logic [T_W-1:0]  t;
  logic [P_W-1:0]  prod;
  logic [T_W-1:0]  mul_a;
  logic [MAG_W-1:0] mul_b;
  logic [CM_W-1:0] xm, ym, zm;

  ssmg_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

  ssmg_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .angle(cor_angle),
    .done(cor_done), .result(cor_res)
  );

  // point count setup
  logic signed [AZ_W:0] az_diff;
  logic signed [EL_W:0] el_diff;
  logic [DIVISOR_W-1:0] az_units, el_units;
  logic [CNT_W:0] q_plus;
  logic [CNT_W-1:0] q_count;

  assign az_diff = {az_end[AZ_W-1], az_end} - {az_start[AZ_W-1], az_start};
  assign el_diff = {el_end[EL_W-1], el_end} - {el_start[EL_W-1], el_start};
  assign az_units = (az_step == '0) ? DIVISOR_W'(1) : az_step;
  assign el_units = (el_step == '0) ? DIVISOR_W'(1) : DIVISOR_W'(el_step);
  assign q_plus = (CNT_W + 1)'(div_q) + 1'b1;
  assign q_count = (div_q > DIV_W'(COUNT_MAX - 1'b1)) ? COUNT_MAX : q_plus[CNT_W-1:0];

  // result fields
  logic [CNT_W:0] col_p1, row_p1;
  logic cell_valid, last;
  logic [INDEX_BITS:0] b_sum, c_sum, d_sum, v_sum;
  logic [INDEX_BITS-1:0] b_idx, c_idx, d_idx, v_next;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  assign col_p1 = {1'b0, col} + 1'b1;
  assign row_p1 = {1'b0, row} + 1'b1;
  assign cell_valid = (col_p1 < {1'b0, cols}) && (row_p1 < {1'b0, rows});
  assign last = (col_p1 == {1'b0, cols}) && (row_p1 == {1'b0, rows});
  assign v_sum = {1'b0, vcount} + 1'b1;
  assign v_next = v_sum[INDEX_BITS] ? IDX_MAX : v_sum[INDEX_BITS-1:0];
  assign b_idx = v_next;
  assign c_sum = {1'b0, vcount} + (INDEX_BITS + 1)'(rows);
  assign c_idx = c_sum[INDEX_BITS] ? IDX_MAX : c_sum[INDEX_BITS-1:0];
  assign d_sum = {1'b0, c_idx} + 1'b1;
  assign d_idx = d_sum[INDEX_BITS] ? IDX_MAX : d_sum[INDEX_BITS-1:0];

  function automatic logic [COORD_W-1:0] coord(input logic [CM_W-1:0] mag, input logic neg);
    logic [COORD_W-1:0] m;
    m = (mag > CM_W'(16'hFFFF)) ? COORD_W'(16'hFFFF) : COORD_W'(mag);
    return neg ? -m : m;
  endfunction

  always_comb begin
    mul_a = T_W'(radius);
    mul_b = trig_el.cmag;
    unique case (state)
      S_MUL_SA: begin
        mul_a = t;
        mul_b = trig_az.smag;
      end
      S_MUL_CA: begin
        mul_a = t;
        mul_b = trig_az.cmag;
      end
      S_MUL_SE: begin
        mul_a = T_W'(radius);
        mul_b = trig_el.smag;
      end
      default: begin
        mul_a = T_W'(radius);
        mul_b = trig_el.cmag;
      end
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      az_start <= '0;
      az_end   <= AZ_W'(5760);
      el_start <= '0;
      el_end   <= EL_W'(2880);
      az_step  <= 9'd10;
      el_step  <= 8'd10;
      radius   <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AZ_START: az_start <= cfg_data;
        REG_AZ_END:   az_end   <= cfg_data;
        REG_EL_START: el_start <= cfg_data[EL_W-1:0];
        REG_EL_END:   el_end   <= cfg_data[EL_W-1:0];
        REG_AZ_STEP:  az_step  <= cfg_data[8:0];
        REG_EL_STEP:  el_step  <= cfg_data[7:0];
        REG_RADIUS:   radius   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    cor_start <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      az_now   <= '0;
      el_now   <= '0;
      col      <= '0;
      row      <= '0;
      rows     <= '0;
      cols     <= '0;
      vcount   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tdata[0]) begin
              div_start    <= 1'b1;
              div_dividend <= el_diff[EL_W] ? '0 : DIV_W'(el_diff[EL_W:AFB]);
              div_divisor  <= el_units;
              state        <= S_DIV_EL;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_DIV_EL: begin
          if (div_done) begin
            rows         <= el_diff[EL_W] ? '0 : q_count;
            div_start    <= 1'b1;
            div_dividend <= az_diff[AZ_W] ? '0 : DIV_W'(az_diff[AZ_W:AFB]);
            div_divisor  <= az_units;
            state        <= S_DIV_AZ;
          end
        end
        S_DIV_AZ: begin
          if (div_done) begin
            cols   <= (az_diff[AZ_W] || rows == '0) ? '0 : q_count;
            az_now <= az_start;
            el_now <= el_start;
            col    <= '0;
            row    <= '0;
            vcount <= '0;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (col >= cols) begin
            state <= S_IDLE;
          end else begin
            cor_start <= 1'b1;
            cor_angle <= az_now;
            state     <= S_TRIG_AZ;
          end
        end
        S_TRIG_AZ: begin
          if (cor_done) begin
            trig_az   <= cor_res;
            cor_start <= 1'b1;
            cor_angle <= AZ_W'(el_now);
            state     <= S_TRIG_EL;
          end
        end
        S_TRIG_EL: begin
          if (cor_done) begin
            trig_el <= cor_res;
            state   <= S_MUL_CE;
          end
        end
        S_MUL_CE: begin
          prod  <= P_W'(mul_a) * P_W'(mul_b);
          state <= S_ROUND_T;
        end
        S_ROUND_T: begin
          t     <= T_W'((prod + P_W'(1 << 13)) >> 14);
          state <= S_MUL_SA;
        end
        S_MUL_SA: begin
          prod  <= P_W'(mul_a) * P_W'(mul_b);
          state <= S_MUL_CA;
        end
        S_MUL_CA: begin
          xm    <= CM_W'((prod + (P_W'(1) << 45)) >> 46);
          prod  <= P_W'(mul_a) * P_W'(mul_b);
          state <= S_MUL_SE;
        end
        S_MUL_SE: begin
          ym    <= CM_W'((prod + (P_W'(1) << 45)) >> 46);
          prod  <= P_W'(mul_a) * P_W'(mul_b);
          state <= S_ZMAG;
        end
        S_ZMAG: begin
          zm    <= CM_W'((prod + (P_W'(1) << 29)) >> 30);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= cell_valid;
            m_tlast  <= last;
            m_tdata  <= {1'b0,
                         cell_valid ? d_idx : '0,
                         cell_valid ? c_idx : '0,
                         cell_valid ? b_idx : '0,
                         cell_valid ? vcount : '0,
                         vcount,
                         coord(zm, trig_el.sneg),
                         coord(ym, trig_el.cneg ^ trig_az.cneg),
                         coord(xm, trig_el.cneg ^ trig_az.sneg)};
            vcount <= v_next;
            if (row_p1 >= {1'b0, rows}) begin
              row    <= '0;
              el_now <= el_start;
              col    <= col + 1'b1;
              az_now <= az_now + AZ_W'({az_units, {AFB{1'b0}}});
            end else begin
              row    <= row + 1'b1;
              el_now <= el_now + EL_W'({el_units, {AFB{1'b0}}});
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[bench/spherical_sector_mesh_generator_tb.sv]
// Self-checking testbench for the spherical sector mesh generator grid walk.
`timescale 1ns / 1ps

module spherical_sector_mesh_generator_tb;
  import ssmg_pkg::*;

  typedef enum {ROW_CFG, ROW_ADV, ROW_RESTART} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cfg_reg_t  idx;
    int        val;
    bit        known;
    bit        has;
    int        x, y, z, vn;
  } row_t;

  typedef struct {
    logic signed [16:0] x, y, z;
    logic [19:0]        vn, a, b, c, d;
    logic               cell_valid, last;
  } vertex_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [7:0] s_tdata = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [151:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;

  spherical_sector_mesh_generator dut (.*);

  initial forever #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  // predictor copy of registers and walk state
  logic [15:0] az_start_r, az_end_r, radius_r;
  logic [13:0] el_start_r, el_end_r;
  logic [8:0]  az_step_r;
  logic [7:0]  el_step_r;
  logic [15:0] az_now;
  logic [13:0] el_now;
  int unsigned col_idx, row_idx, rows_n, cols_n;
  longint unsigned vtx_idx;

  vertex_t vertex_q[$];
  int errors = 0;
  bit quiet = 0;
  int stall_cnt = 0;
  int produced = 0;

  longint atan_tab[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  function automatic longint step_units(int unsigned deg);
    return longint'(deg == 0 ? 1 : deg) << ANGLE_FRACTION_BITS;
  endfunction

  function automatic longint unsigned sat_index(longint unsigned v);
    longint unsigned mx = (64'd1 << INDEX_BITS) - 1;
    return v > mx ? mx : v;
  endfunction

  function automatic void sincos(input longint ang, output longint unsigned smag,
                                 output bit sneg, output longint unsigned cmag,
                                 output bit cneg);
    longint full = 360 << ANGLE_FRACTION_BITS;
    longint half = 180 << ANGLE_FRACTION_BITS;
    longint quarter = 90 << ANGLE_FRACTION_BITS;
    longint r, x, y, z, xs, ys;
    bit flip, neg;
    flip = 0;
    r = ang % full;
    if (r < 0) r += full;
    if (r >= half) r -= full;
    if (r > quarter) begin r -= half; flip = 1; end
    if (r < -quarter) begin r += half; flip = 1; end
    neg = r < 0;
    if (neg) r = -r;
    z = longint'((longint'(r) * 64'd4797524518 + (64'd1 << (7 + ANGLE_FRACTION_BITS)))
        >> (8 + ANGLE_FRACTION_BITS));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_ROUNDS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin x -= ys; y += xs; z -= atan_tab[i]; end
      else begin x += ys; y -= xs; z += atan_tab[i]; end
    end
    cneg = flip ^ (x < 0);
    cmag = x < 0 ? -x : x;
    sneg = flip ^ neg ^ (y < 0);
    smag = y < 0 ? -y : y;
  endfunction

  function automatic logic signed [16:0] to_coord(longint unsigned mag, bit neg);
    logic [16:0] m;
    if (mag > 65535) mag = 65535;
    m = mag[16:0];
    return neg ? -m : m;
  endfunction

  function automatic int unsigned points(longint s, longint e, longint st);
    longint n;
    if (e < s) return 0;
    n = (e - s) / st + 1;
    return n > 1023 ? 1023 : n;
  endfunction

  function automatic bit next_vertex(input bit restart, output vertex_t v);
    longint unsigned sa, ca, se, ce, t, rad, a, c;
    bit nsa, nca, nse, nce;
    v = '{default: 0};
    rad = radius_r;
    if (restart) begin
      rows_n = points($signed(el_start_r), $signed(el_end_r), step_units(el_step_r));
      cols_n = rows_n == 0 ? 0 :
               points($signed(az_start_r), $signed(az_end_r), step_units(az_step_r));
      az_now = az_start_r;
      el_now = el_start_r;
      col_idx = 0;
      row_idx = 0;
      vtx_idx = 0;
    end
    if (col_idx >= cols_n) return 0;
    sincos($signed(az_now), sa, nsa, ca, nca);
    sincos($signed(el_now), se, nse, ce, nce);
    t = (rad * ce + (64'd1 << 13)) >> 14;
    v.x = to_coord((t * sa + (64'd1 << 45)) >> 46, nce ^ nsa);
    v.y = to_coord((t * ca + (64'd1 << 45)) >> 46, nce ^ nca);
    v.z = to_coord((rad * se + (64'd1 << 29)) >> 30, nse);
    v.vn = vtx_idx;
    v.cell_valid = col_idx + 1 < cols_n && row_idx + 1 < rows_n;
    v.last = col_idx + 1 == cols_n && row_idx + 1 == rows_n;
    if (v.cell_valid) begin
      a = vtx_idx;
      c = sat_index(a + rows_n);
      v.a = a;
      v.b = sat_index(a + 1);
      v.c = c;
      v.d = sat_index(c + 1);
    end
    vtx_idx = sat_index(vtx_idx + 1);
    if (row_idx + 1 >= rows_n) begin
      row_idx = 0;
      el_now = el_start_r;
      col_idx++;
      az_now = $signed(az_now) + step_units(az_step_r);
    end else begin
      row_idx++;
      el_now = $signed(el_now) + step_units(el_step_r);
    end
    return 1;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic void expect_vertex(vertex_t v);
    vertex_q = {vertex_q, v};
  endfunction

  always @(posedge clk) begin
    if (quiet) m_tready <= 1;
    else if (stall_cnt > 0) begin
      stall_cnt--;
      m_tready <= 0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_cnt = $urandom_range(0, 4);
      m_tready <= 0;
    end else m_tready <= 1;
  end

  always @(posedge clk) begin
    vertex_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (vertex_q.size() == 0) begin
        $error("result transaction with no vertex expected");
        errors++;
      end else begin
        e = vertex_q.pop_front();
        check_field("pos_x", e.x, $signed(m_tdata[16:0]));
        check_field("pos_y", e.y, $signed(m_tdata[33:17]));
        check_field("pos_z", e.z, $signed(m_tdata[50:34]));
        check_field("vertex_number", e.vn, m_tdata[70:51]);
        check_field("corner_a", e.a, m_tdata[90:71]);
        check_field("corner_b", e.b, m_tdata[110:91]);
        check_field("corner_c", e.c, m_tdata[130:111]);
        check_field("corner_d", e.d, m_tdata[150:131]);
        check_field("cell_valid", e.cell_valid, m_tuser);
        check_field("last_vertex", e.last, m_tlast);
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk); while (vertex_q.size() != 0 || !s_tready);
    repeat (100) @(posedge clk);
  endtask

  // caller lowers cfg_we after the last write of a series
  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    case (idx)
      REG_AZ_START: az_start_r = val[15:0];
      REG_AZ_END:   az_end_r = val[15:0];
      REG_EL_START: el_start_r = val[13:0];
      REG_EL_END:   el_end_r = val[13:0];
      REG_AZ_STEP:  az_step_r = val[8:0];
      REG_EL_STEP:  el_step_r = val[7:0];
      REG_RADIUS:   radius_r = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_item(input bit restart, output bit got, output vertex_t v);
    int gap;
    s_tvalid <= 1;
    s_tdata <= {7'd0, restart};
    do @(posedge clk); while (!s_tready);
    got = next_vertex(restart, v);
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_sender();
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic random_config();
    int mode, ast, est, s, e, k;
    mode = $urandom_range(0, 9);
    idle_sender();
    wait_idle();
    if (mode == 0) begin
      write_reg(REG_AZ_START, $urandom_range(0, 65535));
      write_reg(REG_AZ_END, $urandom_range(0, 65535));
      write_reg(REG_EL_START, $urandom_range(0, 16383));
      write_reg(REG_EL_END, $urandom_range(0, 16383));
      write_reg(REG_AZ_STEP, $urandom_range(0, 511));
      write_reg(REG_EL_STEP, $urandom_range(0, 255));
    end else if (mode == 1) begin
      // wide azimuth, count saturates
      write_reg(REG_AZ_START, -32768);
      write_reg(REG_AZ_END, 32767);
      write_reg(REG_AZ_STEP, 1);
      write_reg(REG_EL_START, $urandom_range(0, 1) ? 8191 : -8192);
      write_reg(REG_EL_END, 8191);
      write_reg(REG_EL_STEP, $urandom_range(0, 255));
    end else begin
      ast = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 360);
      est = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 180);
      s = $urandom_range(0, 46080) - 23040;
      k = $urandom_range(0, 7);
      e = s + (ast == 0 ? 1 : ast) * 64 * k + $urandom_range(0, 63);
      if (e > 23040) e = 23040;
      if (mode == 2) e = s - $urandom_range(1, 100);
      write_reg(REG_AZ_START, s);
      write_reg(REG_AZ_END, e);
      write_reg(REG_AZ_STEP, ast);
      s = $urandom_range(0, 11520) - 5760;
      k = $urandom_range(0, 7);
      e = s + (est == 0 ? 1 : est) * 64 * k + $urandom_range(0, 63);
      if (e > 5760) e = 5760;
      write_reg(REG_EL_START, s);
      write_reg(REG_EL_END, e);
      write_reg(REG_EL_STEP, est);
    end
    case ($urandom_range(0, 5))
      0: write_reg(REG_RADIUS, 0);
      1: write_reg(REG_RADIUS, 65535);
      default: write_reg(REG_RADIUS, $urandom_range(0, 65535));
    endcase
    cfg_we <= 0;
  endtask

  row_t rows[$];

  task automatic add_row(row_kind_t kind, cfg_reg_t idx, int val,
                         bit known = 0, bit has = 0, int x = 0, int y = 0, int z = 0,
                         int vn = 0);
    rows = {rows, row_t'{kind, idx, val, known, has, x, y, z, vn}};
  endtask

  initial begin
    vertex_t v;
    bit got;
    bit prev_cfg;
    int attempts;

    az_start_r = 0; az_end_r = 5760; el_start_r = 0; el_end_r = 2880;
    az_step_r = 10; el_step_r = 10; radius_r = 1000;
    az_now = 0; el_now = 0; col_idx = 0; row_idx = 0; vtx_idx = 0;
    rows_n = 0; cols_n = 0;

    add_row(ROW_ADV, REG_AZ_START, 0, 1, 0);
    add_row(ROW_RESTART, REG_AZ_START, 0, 1, 1, 0, 1000, 0, 0);
    add_row(ROW_ADV, REG_AZ_START, 0);
    add_row(ROW_ADV, REG_AZ_START, 0);
    add_row(ROW_CFG, REG_RADIUS, 0);
    add_row(ROW_RESTART, REG_AZ_START, 0, 1, 1, 0, 0, 0, 0);
    add_row(ROW_CFG, REG_RADIUS, 65535);
    add_row(ROW_CFG, REG_AZ_START, -23040);
    add_row(ROW_CFG, REG_AZ_END, 23040);
    add_row(ROW_CFG, REG_EL_START, -5760);
    add_row(ROW_CFG, REG_EL_END, 5760);
    add_row(ROW_CFG, REG_AZ_STEP, 0);
    add_row(ROW_CFG, REG_EL_STEP, 0);
    add_row(ROW_RESTART, REG_AZ_START, 0);
    add_row(ROW_ADV, REG_AZ_START, 0);
    add_row(ROW_CFG, REG_AZ_STEP, 360);
    add_row(ROW_CFG, REG_EL_STEP, 180);
    add_row(ROW_RESTART, REG_AZ_START, 0);
    repeat (5) add_row(ROW_ADV, REG_AZ_START, 0);
    add_row(ROW_ADV, REG_AZ_START, 0, 1, 0);
    add_row(ROW_CFG, REG_EL_START, 100);
    add_row(ROW_CFG, REG_EL_END, 0);
    add_row(ROW_RESTART, REG_AZ_START, 0, 1, 0);

    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    prev_cfg = 0;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (!prev_cfg) begin
          idle_sender();
          wait_idle();
        end
        write_reg(rows[i].idx, rows[i].val);
        prev_cfg = 1;
      end else begin
        if (prev_cfg) cfg_we <= 0;
        prev_cfg = 0;
        send_item(rows[i].kind == ROW_RESTART, got, v);
        if (rows[i].known) begin
          if (got != rows[i].has) begin
            $error("result count expected %0d actual %0d", rows[i].has, got);
            errors++;
          end
          got = rows[i].has;
          v.x = rows[i].x; v.y = rows[i].y; v.z = rows[i].z; v.vn = rows[i].vn;
        end
        if (got) expect_vertex(v);
      end
    end

    for (int phase = 0; phase < 11; phase++) begin
      if (phase == 10) quiet = 1;
      if (phase == 6) begin
        // live register change in the middle of a walk
        idle_sender();
        wait_idle();
        write_reg(REG_RADIUS, $urandom_range(0, 65535));
        write_reg(REG_EL_STEP, $urandom_range(0, 255));
        cfg_we <= 0;
      end else random_config();
      attempts = 0;
      produced = 0;
      while (produced < 130 && attempts < 260) begin
        attempts++;
        if (col_idx >= cols_n)
          send_item($urandom_range(0, 9) != 0, got, v);
        else
          send_item($urandom_range(0, 39) == 0, got, v);
        if (got) begin
          expect_vertex(v);
          produced++;
        end
        if (produced == 60 && phase == 3) begin
          s_tvalid <= 0;
          do @(posedge clk); while (vertex_q.size() != 0);
        end
      end
    end

    s_tvalid <= 0;
    do @(posedge clk); while (vertex_q.size() != 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
